>>> rtl/bole_pkg.sv
`default_nettype none

package bole_pkg;

   // list depth
   localparam int CAPACITY = 16;

   // fixed word field widths
   localparam int MODE_W   = 4;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 3;
   localparam int RIDX_W   = 4;
   localparam int COUNT_W  = 5;

   // internal widths that follow the depth
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_PREPEND    = 4'd0;
   localparam logic [MODE_W-1:0] MODE_APPEND     = 4'd1;
   localparam logic [MODE_W-1:0] MODE_INSERT     = 4'd2;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 4'd3;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 4'd4;
   localparam logic [MODE_W-1:0] MODE_REMOVE_AT  = 4'd5;
   localparam logic [MODE_W-1:0] MODE_REMOVE_VAL = 4'd6;
   localparam logic [MODE_W-1:0] MODE_READ_AT    = 4'd7;
   localparam logic [MODE_W-1:0] MODE_FIND       = 4'd8;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 4'd9;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

   // controller to datapath commands
   typedef struct packed {
      logic load;   // capture request word
      logic scan;   // register compare vector
      logic exec;   // update list, register response
   } cmd_type;

endpackage

`default_nettype wire

>>> rtl/bole_ctrl.sv
`default_nettype none

module bole_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output bole_pkg::cmd_type   cmd
);
   import bole_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EXEC,
      S_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_SCAN;
         S_SCAN: state_in = S_EXEC;
         S_EXEC: state_in = S_RESP;
         S_RESP: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   assign cmd.load = req_valid && (state_ff == S_IDLE);
   assign cmd.scan = (state_ff == S_SCAN);
   assign cmd.exec = (state_ff == S_EXEC);

endmodule

`default_nettype wire

>>> rtl/bole_datapath.sv
`default_nettype none

module bole_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire bole_pkg::cmd_type                    cmd,
   input  wire logic        [bole_pkg::MODE_W-1:0]   req_mode,
   input  wire logic signed [bole_pkg::VALUE_W-1:0]  req_value,
   input  wire logic        [bole_pkg::POS_W-1:0]    req_position,
   output logic             [bole_pkg::STATUS_W-1:0] rsp_status,
   output logic signed      [bole_pkg::VALUE_W-1:0]  rsp_result_value,
   output logic             [bole_pkg::RIDX_W-1:0]   rsp_result_index,
   output logic             [bole_pkg::COUNT_W-1:0]  rsp_item_count,
   output logic                                      rsp_list_empty
);
   import bole_pkg::*;

   // captured request word
   logic [MODE_W-1:0]  mode_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [POS_W-1:0]   pos_ff;

   // list cells and fill count
   logic [VALUE_W-1:0] cells_ff [CAPACITY];
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   // registered compare vector
   logic [CAPACITY-1:0] match_ff;
   logic [CAPACITY-1:0] match_in;

   // response registers
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [VALUE_W-1:0]  rval_ff, rval_in;
   logic [IDX_W-1:0]    ridx_ff, ridx_in;

   // execute-stage decode
   logic             found;
   logic [IDX_W-1:0] hit_idx;
   logic [IDX_W-1:0] at_idx;
   logic [CMP_W-1:0] count_ext;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] ins_at;
   logic [CNT_W-1:0] count_m1;
   logic             do_insert;
   logic             do_remove;
   logic             do_read;
   logic             do_clear;
   logic [VALUE_W-1:0] cell_rd;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
   end

   // parallel compare against live cells
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match_in[i] = (cells_ff[i] == value_ff) && (CNT_W'(i) < count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         match_ff <= match_in;
      end
   end

   // lowest matching position
   always_comb begin
      hit_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match_ff[i]) hit_idx = IDX_W'(i);
      end
   end

   assign found     = |match_ff;
   assign count_ext = CMP_W'(count_ff);
   assign pos_ext   = CMP_W'(pos_ff);
   assign count_m1  = count_ff - CNT_W'(1);

   always_comb begin
      ins_at    = '0;
      at_idx    = '0;
      status_in = ST_OK;
      do_insert = 1'b0;
      do_remove = 1'b0;
      do_read   = 1'b0;
      do_clear  = 1'b0;
      unique case (mode_ff)
         MODE_PREPEND, MODE_APPEND, MODE_INSERT: begin
            priority if (mode_ff == MODE_PREPEND) ins_at = '0;
            else if (mode_ff == MODE_APPEND)      ins_at = count_ext;
            else                                  ins_at = pos_ext;
            at_idx = ins_at[IDX_W-1:0];
            if (ins_at > count_ext) begin
               status_in = ST_RANGE;
            end else if (count_ff >= CNT_W'(CAPACITY)) begin
               status_in = ST_FULL;
            end else begin
               do_insert = 1'b1;
            end
         end
         MODE_POP_FRONT, MODE_POP_BACK: begin
            at_idx = (mode_ff == MODE_POP_FRONT) ? '0 : count_m1[IDX_W-1:0];
            if (count_ff == '0) status_in = ST_EMPTY;
            else                do_remove = 1'b1;
         end
         MODE_REMOVE_AT: begin
            at_idx = pos_ff[IDX_W-1:0];
            if (count_ff == '0)           status_in = ST_EMPTY;
            else if (pos_ext >= count_ext) status_in = ST_RANGE;
            else                          do_remove = 1'b1;
         end
         MODE_REMOVE_VAL: begin
            at_idx = hit_idx;
            if (count_ff == '0) status_in = ST_EMPTY;
            else if (!found)    status_in = ST_NOTFOUND;
            else                do_remove = 1'b1;
         end
         MODE_READ_AT: begin
            at_idx = pos_ff[IDX_W-1:0];
            if (pos_ext >= count_ext) status_in = ST_RANGE;
            else                      do_read = 1'b1;
         end
         MODE_FIND: begin
            at_idx = hit_idx;
            if (!found) status_in = ST_NOTFOUND;
            else        do_read = 1'b1;
         end
         MODE_CLEAR: do_clear = 1'b1;
         default: ;
      endcase
   end

   assign cell_rd = cells_ff[at_idx];

   always_comb begin
      rval_in = (do_remove || do_read) ? cell_rd : '0;
      ridx_in = (do_remove || do_read || do_insert) ? at_idx : '0;
      priority if (do_clear)  count_in = '0;
      else if (do_insert)     count_in = count_ff + CNT_W'(1);
      else if (do_remove)     count_in = count_m1;
      else                    count_in = count_ff;
   end

   // each cell shifts from a neighbor, takes the new value, or holds
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VALUE_W-1:0] lower;
      logic [VALUE_W-1:0] upper;
      logic [VALUE_W-1:0] cell_in;

      if (g == 0) begin : g_lo
         assign lower = value_ff;
      end else begin : g_lo
         assign lower = cells_ff[g-1];
      end

      if (g == CAPACITY - 1) begin : g_hi
         assign upper = cells_ff[g];
      end else begin : g_hi
         assign upper = cells_ff[g+1];
      end

      always_comb begin
         cell_in = cells_ff[g];
         if (do_insert) begin
            if (IDX_W'(g) == at_idx)     cell_in = value_ff;
            else if (IDX_W'(g) > at_idx) cell_in = lower;
         end else if (do_remove) begin
            if (IDX_W'(g) >= at_idx) cell_in = upper;
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.exec) begin
            cells_ff[g] <= cell_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         rval_ff   <= rval_in;
         ridx_ff   <= ridx_in;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_result_value = rval_ff;
   assign rsp_result_index = RIDX_W'(ridx_ff);
   assign rsp_item_count   = COUNT_W'(count_ff);
   assign rsp_list_empty   = (count_ff == '0);

endmodule

`default_nettype wire

>>> rtl/bounded_ordered_list_engine.sv
`default_nettype none

// Channel   Direction  Handshake             Word
// req_      in         req_valid/req_stall   mode, value, position
// rsp_      out        rsp_valid/rsp_stall   status, result_value, result_index,
//                                            item_count, list_empty
//
// One word at a time: accept, compare scan, execute, respond. An operation
// is finished before the next word can be accepted, and rsp_stall holds
// the response until it is taken. The parallel compare is registered before
// the first-match encode and cell shift.
// Reset (synchronous) empties the list; cell contents are not cleared.
// req_stall stays high from accept until the response word is taken.

module bounded_ordered_list_engine (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic        [bole_pkg::MODE_W-1:0]   req_mode,
   input  wire logic signed [bole_pkg::VALUE_W-1:0]  req_value,
   input  wire logic        [bole_pkg::POS_W-1:0]    req_position,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic             [bole_pkg::STATUS_W-1:0] rsp_status,
   output logic signed      [bole_pkg::VALUE_W-1:0]  rsp_result_value,
   output logic             [bole_pkg::RIDX_W-1:0]   rsp_result_index,
   output logic             [bole_pkg::COUNT_W-1:0]  rsp_item_count,
   output logic                                      rsp_list_empty
);
   import bole_pkg::*;

   // sequencing commands: load word, scan compare, execute
   cmd_type cmd;

   // controller: owns handshake and step order
   bole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // datapath: list cells, compare vector, shift network, response regs
   bole_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_mode         (req_mode),
      .req_value        (req_value),
      .req_position     (req_position),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_result_index (rsp_result_index),
      .rsp_item_count   (rsp_item_count),
      .rsp_list_empty   (rsp_list_empty)
   );

endmodule

`default_nettype wire
